[rtl/core/cfrs_pkg.sv]
// Package: widths, constants, opcodes, controller states and command types for the camera frame core.
package cfrs_pkg;

	localparam int CordicSteps  = 24;
	localparam int AxisFracBits = 30;

	localparam int FullTurn    = 92160;
	localparam int HalfTurn    = 46080;
	localparam int QuarterTurn = 23040;
	localparam logic signed [31:0] DegToRadQ32  = 32'sd74961320;
	localparam logic signed [31:0] CordicGainQ30 = 32'sd652032874;

	typedef enum logic [1:0] {
		OP_ROLL  = 2'd0,
		OP_PITCH = 2'd1,
		OP_YAW   = 2'd2,
		OP_SLIDE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_ROT,
		ST_CROSS,
		ST_SLIDE,
		ST_DONE
	} state_t;

	// Step counter width covers CORDIC iterations and three-component sweeps
	localparam int CntW = $clog2(CordicSteps + 1);

	typedef struct packed {
		logic           load;      // latch the item and start angle prep
		logic           cordic;    // run one CORDIC iteration
		logic           rot;       // rotate one component
		logic           crs;       // cross one component
		logic           slide;     // slide one component
		logic [1:0]     comp;      // component index
		logic [CntW-1:0] step;     // CORDIC iteration index
	} cmd_t;

	typedef struct packed {
		op_t op;
	} sts_t;

	function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0:  atan_q30 = 32'sd843314856;
			5'd1:  atan_q30 = 32'sd497837829;
			5'd2:  atan_q30 = 32'sd263043836;
			5'd3:  atan_q30 = 32'sd133525158;
			5'd4:  atan_q30 = 32'sd67021686;
			5'd5:  atan_q30 = 32'sd33543515;
			5'd6:  atan_q30 = 32'sd16775850;
			5'd7:  atan_q30 = 32'sd8388437;
			5'd8:  atan_q30 = 32'sd4194282;
			5'd9:  atan_q30 = 32'sd2097149;
			5'd10: atan_q30 = 32'sd1048575;
			5'd11: atan_q30 = 32'sd524287;
			5'd12: atan_q30 = 32'sd262143;
			5'd13: atan_q30 = 32'sd131071;
			5'd14: atan_q30 = 32'sd65535;
			5'd15: atan_q30 = 32'sd32767;
			5'd16: atan_q30 = 32'sd16383;
			5'd17: atan_q30 = 32'sd8191;
			5'd18: atan_q30 = 32'sd4095;
			5'd19: atan_q30 = 32'sd2047;
			5'd20: atan_q30 = 32'sd1023;
			5'd21: atan_q30 = 32'sd511;
			5'd22: atan_q30 = 32'sd255;
			5'd23: atan_q30 = 32'sd127;
			5'd24: atan_q30 = 32'sd63;
			5'd25: atan_q30 = 32'sd31;
			5'd26: atan_q30 = 32'sd15;
			5'd27: atan_q30 = 32'sd7;
			5'd28: atan_q30 = 32'sd3;
			5'd29: atan_q30 = 32'sd1;
			default: atan_q30 = 32'sd0;
		endcase
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		if (x > 66'sd2147483647)
			sat32 = 32'sh7fffffff;
		else if (x < -66'sd2147483648)
			sat32 = 32'sh80000000;
		else
			sat32 = x[31:0];
	endfunction

endpackage

[rtl/core/cfrs_if.sv]
// Interfaces: valid/ready channels for step commands and frame reports.
interface cfrs_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic signed [17:0] angle_deg;
	logic signed [31:0] move_u;
	logic signed [31:0] move_v;
	logic signed [31:0] move_n;
	modport source (output valid, op, angle_deg, move_u, move_v, move_n, input ready);
	modport sink   (input valid, op, angle_deg, move_u, move_v, move_n, output ready);
endinterface

interface cfrs_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] eye_x, eye_y, eye_z;
	logic signed [31:0] u_x, u_y, u_z;
	logic signed [31:0] v_x, v_y, v_z;
	logic signed [31:0] n_x, n_y, n_z;
	modport source (output valid, eye_x, eye_y, eye_z, u_x, u_y, u_z,
		v_x, v_y, v_z, n_x, n_y, n_z, input ready);
	modport sink   (input valid, eye_x, eye_y, eye_z, u_x, u_y, u_z,
		v_x, v_y, v_z, n_x, n_y, n_z, output ready);
endinterface

[rtl/core/cfrs_ctrl.sv]
// Controller: sequences angle prep, CORDIC, rotate, cross and slide per component.
module cfrs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  cfrs_pkg::sts_t  sts,
	output cfrs_pkg::cmd_t  cmd
);
	import cfrs_pkg::*;

	state_t          state_q, state_d;
	logic [CntW-1:0] cnt_q, cnt_d;
	logic            pend_q;

	// Advance state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					cnt_d   = '0;
					state_d = ST_CORDIC;
				end
			end
			ST_CORDIC: begin
				// first cycle of this state after load carries op decision
				if (sts.op == OP_SLIDE) begin
					state_d = ST_SLIDE;
					cnt_d   = '0;
				end else if (cnt_q == CntW'(CordicSteps - 1)) begin
					state_d = ST_ROT;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_ROT: begin
				if (cnt_q == CntW'(2)) begin
					state_d = ST_CROSS;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_CROSS, ST_SLIDE: begin
				if (cnt_q == CntW'(2)) begin
					state_d = ST_DONE;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Track an undelivered report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= 1'b0;
		else if (state_q == ST_DONE)
			pend_q <= 1'b1;
		else if (out_ready)
			pend_q <= 1'b0;
	end

	// Outputs
	always_comb begin
		cmd        = '0;
		cmd.comp   = cnt_q[1:0];
		cmd.step   = cnt_q;
		in_ready   = (state_q == ST_IDLE) && !pend_q;
		out_valid  = pend_q;
		cmd.load   = in_valid && in_ready;
		cmd.cordic = (state_q == ST_CORDIC) && (sts.op != OP_SLIDE);
		cmd.rot    = (state_q == ST_ROT);
		cmd.crs    = (state_q == ST_CROSS);
		cmd.slide  = (state_q == ST_SLIDE);
	end
endmodule

[rtl/core/cfrs_dp.sv]
// Datapath: frame registers, angle reduction, CORDIC unit and per-component multiply.
module cfrs_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  cfrs_pkg::cmd_t     cmd,
	output cfrs_pkg::sts_t     sts,
	input  logic [1:0]         in_op,
	input  logic signed [17:0] in_angle,
	input  logic signed [31:0] in_mu,
	input  logic signed [31:0] in_mv,
	input  logic signed [31:0] in_mn,
	output logic signed [31:0] eye_o [3],
	output logic signed [31:0] u_o [3],
	output logic signed [31:0] v_o [3],
	output logic signed [31:0] n_o [3]
);
	import cfrs_pkg::*;

	localparam logic signed [31:0] One = 32'sd1 <<< AxisFracBits;

	logic signed [31:0] eye_q [3];
	logic signed [31:0] u_q [3];
	logic signed [31:0] v_q [3];
	logic signed [31:0] n_q [3];
	op_t                op_q;
	logic               negc_q;
	logic signed [31:0] mu_q, mv_q, mn_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic signed [33:0] c_q;

	// Angle reduction into [-90, 90] degrees
	logic signed [17:0] r0, r1, r2;
	logic               nc;
	logic signed [51:0] zprod;
	always_comb begin
		r0 = in_angle;
		if (r0 >= 18'sd46080)
			r0 = r0 - 18'sd92160;
		else if (r0 < -18'sd46080)
			r0 = r0 + 18'sd92160;
		r1 = r0;
		if (r1 >= 18'sd46080)
			r1 = r1 - 18'sd92160;
		r2 = r1;
		nc = 1'b0;
		if (r1 > 18'sd23040) begin
			r2 = 18'sd46080 - r1;
			nc = 1'b1;
		end else if (r1 < -18'sd23040) begin
			r2 = -18'sd46080 - r1;
			nc = 1'b1;
		end
		zprod = 52'(r2) * 52'(DegToRadQ32) + 52'sd512;
	end

	// CORDIC iteration
	logic signed [33:0] xs, ys, nx, ny, nz, at;
	always_comb begin
		xs = x_q >>> cmd.step;
		ys = y_q >>> cmd.step;
		at = 34'(atan_q30(5'(cmd.step)));
		if (!z_q[33]) begin
			nx = x_q - ys; ny = y_q + xs; nz = z_q - at;
		end else begin
			nx = x_q + ys; ny = y_q - xs; nz = z_q + at;
		end
	end

	// Rotation operands for one component
	logic signed [31:0] ra, rb;
	logic signed [65:0] rsum;
	logic signed [31:0] rres;
	logic               rneg;
	always_comb begin
		ra = (op_q == OP_PITCH) ? v_q[cmd.comp] : u_q[cmd.comp];
		rb = (op_q == OP_ROLL) ? v_q[cmd.comp] : n_q[cmd.comp];
		rneg = (op_q == OP_ROLL);
		if (rneg)
			rsum = 66'(c_q * ra) - 66'(y_q * rb);
		else
			rsum = 66'(c_q * ra) + 66'(y_q * rb);
		rres = sat32((rsum + (66'sd1 <<< 29)) >>> 30);
	end

	// Cross product for one component: roll gives n x u, others u x v
	logic signed [31:0] ca [3];
	logic signed [31:0] cb [3];
	logic signed [31:0] a1, b1, a2, b2;
	logic signed [65:0] h;
	logic signed [31:0] cres;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ca[k] = (op_q == OP_ROLL) ? n_q[k] : u_q[k];
			cb[k] = (op_q == OP_ROLL) ? u_q[k] : v_q[k];
		end
		case (cmd.comp)
			2'd0: begin a1 = ca[1]; b1 = cb[2]; a2 = ca[2]; b2 = cb[1]; end
			2'd1: begin a1 = ca[2]; b1 = cb[0]; a2 = ca[0]; b2 = cb[2]; end
			default: begin a1 = ca[0]; b1 = cb[1]; a2 = ca[1]; b2 = cb[0]; end
		endcase
		h = (66'(a1 * b1) >>> 1) - (66'(a2 * b2) >>> 1) + (66'sd1 <<< (AxisFracBits - 2));
		cres = sat32(h >>> (AxisFracBits - 1));
	end

	// Slide for one component
	logic signed [65:0] ssum;
	logic signed [31:0] sres;
	always_comb begin
		ssum = (66'(mu_q * u_q[cmd.comp]) >>> 2) + (66'(mv_q * v_q[cmd.comp]) >>> 2)
			+ (66'(mn_q * n_q[cmd.comp]) >>> 2);
		ssum = (ssum + (66'sd1 <<< (AxisFracBits - 3))) >>> (AxisFracBits - 2);
		sres = sat32(66'(eye_q[cmd.comp]) + ssum);
	end

	// Hold item fields and CORDIC registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op_t'(in_op);
			negc_q <= nc;
			mu_q   <= in_mu; mv_q <= in_mv; mn_q <= in_mn;
			x_q    <= 34'(CordicGainQ30);
			y_q    <= '0;
			z_q    <= 34'(zprod >>> 10);
		end else if (cmd.cordic) begin
			x_q <= nx; y_q <= ny; z_q <= nz;
			if (cmd.step == CntW'(CordicSteps - 1))
				c_q <= negc_q ? -nx : nx;
		end
	end

	// Frame registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_q <= '{32'sd0, 32'sd3938058, 32'sd240845};
			u_q   <= '{One, 32'sd0, 32'sd0};
			v_q   <= '{32'sd0, 32'sd0, One};
			n_q   <= '{32'sd0, -One, 32'sd0};
		end else if (cmd.rot) begin
			if (op_q == OP_PITCH) v_q[cmd.comp] <= rres;
			else u_q[cmd.comp] <= rres;
		end else if (cmd.crs) begin
			if (op_q == OP_ROLL) v_q[cmd.comp] <= cres;
			else n_q[cmd.comp] <= cres;
		end else if (cmd.slide) begin
			eye_q[cmd.comp] <= sres;
		end
	end

	assign sts.op = op_q;
	assign eye_o = eye_q;
	assign u_o = u_q;
	assign v_o = v_q;
	assign n_o = n_q;
endmodule

[rtl/core/camera_frame_rotate_slide_top.sv]
// Rotation: load, CORDIC iterations, rotate and cross of each component, ST_DONE, then report valid.
// Slide: load, op decision in ST_CORDIC, slide of each component, ST_DONE, then report valid.
// One item in flight; next item taken once the report has been transferred.
// Reset: arst_n asynchronously restores the initial camera frame and idles.
module camera_frame_rotate_slide_top (
	input logic       clk,
	input logic       arst_n,
	cfrs_in_if.sink   in_ch,
	cfrs_out_if.source out_ch
);
	import cfrs_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic signed [31:0] eye [3];
	logic signed [31:0] u [3];
	logic signed [31:0] v [3];
	logic signed [31:0] n [3];

	cfrs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	cfrs_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_op(in_ch.op), .in_angle(in_ch.angle_deg),
		.in_mu(in_ch.move_u), .in_mv(in_ch.move_v), .in_mn(in_ch.move_n),
		.eye_o(eye), .u_o(u), .v_o(v), .n_o(n)
	);

	// Drive the report from the frame registers
	assign out_ch.eye_x = eye[0];
	assign out_ch.eye_y = eye[1];
	assign out_ch.eye_z = eye[2];
	assign out_ch.u_x = u[0];
	assign out_ch.u_y = u[1];
	assign out_ch.u_z = u[2];
	assign out_ch.v_x = v[0];
	assign out_ch.v_y = v[1];
	assign out_ch.v_z = v[2];
	assign out_ch.n_x = n[0];
	assign out_ch.n_y = n[1];
	assign out_ch.n_z = n[2];
endmodule

[rtl/core/cfrs_chk.sv]
// Checker: port-level properties of the camera frame core, bound to the top level.
module cfrs_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [31:0] eye_x
);
	// No new item accepted while a report waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input ready while report pending");

	// Report not yet valid in the cycle after acceptance
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid) else $error("report too early");

	// Report valid and eye_x hold until transferred
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(eye_x))
		else $error("report dropped");
endmodule

bind camera_frame_rotate_slide_top cfrs_chk u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.eye_x(out_ch.eye_x)
);

[test/tb_camera_frame_rotate_slide_top.sv]
// Testbench: camera frame rotate/slide core checked against a cycle-free frame predictor.
module tb_camera_frame_rotate_slide_top;
	import cfrs_pkg::*;

	typedef struct {
		logic signed [31:0] eye [3];
		logic signed [31:0] u [3];
		logic signed [31:0] v [3];
		logic signed [31:0] n [3];
	} frame_t;

	// Predicted frame state plus queue of expected reports
	class frame_scoreboard;
		frame_t cur;
		frame_t pending [$];
		int mismatches;
		int reports;

		function new();
			longint one;
			one = longint'(1) << AxisFracBits;
			cur.eye = '{0, 3938058, 240845};
			cur.u = '{32'(one), 0, 0};
			cur.v = '{0, 0, 32'(one)};
			cur.n = '{0, 32'(-one), 0};
			mismatches = 0;
			reports = 0;
		endfunction

		function longint clamp32(longint x);
			if (x > 64'sd2147483647) return 64'sd2147483647;
			if (x < -64'sd2147483648) return -64'sd2147483648;
			return x;
		endfunction

		function void sin_cos(longint adeg, output longint c, output longint s);
			longint r, x, y, z, nx;
			bit flip;
			r = adeg % FullTurn;
			flip = 0;
			if (r >= HalfTurn) r -= FullTurn;
			if (r < -HalfTurn) r += FullTurn;
			if (r > QuarterTurn) begin
				r = HalfTurn - r;
				flip = 1;
			end else if (r < -QuarterTurn) begin
				r = -HalfTurn - r;
				flip = 1;
			end
			z = (r * 74961320 + 512) >>> 10;
			x = 652032874;
			y = 0;
			for (int i = 0; i < CordicSteps && i < 30; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z -= atan_q30(5'(i));
				end else begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z += atan_q30(5'(i));
				end
				x = nx;
			end
			c = flip ? -x : x;
			s = y;
		endfunction

		function void turn(ref logic signed [31:0] a [3], input logic signed [31:0] b [3],
				input longint c, input longint s, input bit minus);
			longint t, w;
			logic signed [31:0] r [3];
			for (int k = 0; k < 3; k++) begin
				t = c * longint'(a[k]);
				w = s * longint'(b[k]);
				r[k] = 32'(clamp32(((minus ? t - w : t + w) + (longint'(1) << 29)) >>> 30));
			end
			a = r;
		endfunction

		function logic signed [31:0] cterm(longint a1, longint b1, longint a2, longint b2);
			longint h;
			h = ((a1 * b1) >>> 1) - ((a2 * b2) >>> 1) + (longint'(1) << (AxisFracBits - 2));
			return 32'(clamp32(h >>> (AxisFracBits - 1)));
		endfunction

		function void cross3(ref logic signed [31:0] d [3], input logic signed [31:0] a [3],
				input logic signed [31:0] b [3]);
			d[0] = cterm(a[1], b[2], a[2], b[1]);
			d[1] = cterm(a[2], b[0], a[0], b[2]);
			d[2] = cterm(a[0], b[1], a[1], b[0]);
		endfunction

		// Advance the frame by one accepted command
		function void note_step(op_t op, logic signed [17:0] ang,
				logic signed [31:0] mu, logic signed [31:0] mv, logic signed [31:0] mn);
			longint c, s, sum;
			if (op == OP_SLIDE) begin
				for (int k = 0; k < 3; k++) begin
					sum = ((longint'(mu) * cur.u[k]) >>> 2) + ((longint'(mv) * cur.v[k]) >>> 2)
						+ ((longint'(mn) * cur.n[k]) >>> 2);
					sum = (sum + (longint'(1) << (AxisFracBits - 3))) >>> (AxisFracBits - 2);
					cur.eye[k] = 32'(clamp32(longint'(cur.eye[k]) + sum));
				end
			end else begin
				sin_cos(longint'(ang), c, s);
				case (op)
					OP_ROLL: begin
						turn(cur.u, cur.v, c, s, 1);
						cross3(cur.v, cur.n, cur.u);
					end
					OP_PITCH: begin
						turn(cur.v, cur.n, c, s, 0);
						cross3(cur.n, cur.u, cur.v);
					end
					default: begin
						turn(cur.u, cur.n, c, s, 0);
						cross3(cur.n, cur.u, cur.v);
					end
				endcase
			end
			pending.push_back(cur);
		endfunction

		function void check_report(frame_t got);
			frame_t exp;
			bit bad;
			reports++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected frame report");
				return;
			end
			exp = pending.pop_front();
			bad = 0;
			for (int k = 0; k < 3; k++)
				if (got.eye[k] !== exp.eye[k] || got.u[k] !== exp.u[k] ||
						got.v[k] !== exp.v[k] || got.n[k] !== exp.n[k])
					bad = 1;
			if (bad) begin
				mismatches++;
				if (mismatches <= 10)
					$display("frame mismatch #%0d: exp eye %p u %p v %p n %p / got eye %p u %p v %p n %p",
						reports, exp.eye, exp.u, exp.v, exp.n, got.eye, got.u, got.v, got.n);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	cfrs_in_if in_ch();
	cfrs_out_if out_ch();
	frame_scoreboard board;
	bit idle_on = 1;
	bit hold_sink = 0;
	bit long_hold = 0;
	int quiet_cycles = 0;
	int n_sent = 0;
	int op_count [4] = '{0, 0, 0, 0};

	camera_frame_rotate_slide_top uut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	initial begin
		in_ch.valid = 0;
		in_ch.op = 0;
		in_ch.angle_deg = 0;
		in_ch.move_u = 0;
		in_ch.move_v = 0;
		in_ch.move_n = 0;
		board = new();
	end

	// Note transfers on both channels and watch for a stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				board.note_step(op_t'(in_ch.op), in_ch.angle_deg, in_ch.move_u,
					in_ch.move_v, in_ch.move_n);
			if (out_ch.valid && out_ch.ready)
				board.check_report('{eye: '{out_ch.eye_x, out_ch.eye_y, out_ch.eye_z},
					u: '{out_ch.u_x, out_ch.u_y, out_ch.u_z},
					v: '{out_ch.v_x, out_ch.v_y, out_ch.v_z},
					n: '{out_ch.n_x, out_ch.n_y, out_ch.n_z}});
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > 20000) begin
				$display("tb_camera_frame_rotate_slide_top: errors");
				$finish;
			end
		end
	end

	// Receiver: random stall bursts, long hold-off on request
	always @(posedge clk) begin
		if (!arst_n || hold_sink || long_hold)
			out_ch.ready <= 0;
		else if (idle_on && $urandom_range(0, 3) == 0)
			out_ch.ready <= 0;
		else
			out_ch.ready <= 1;
	end

	initial begin
		int burst;
		forever begin
			@(posedge clk);
			if (idle_on && !hold_sink && $urandom_range(0, 9) == 0) begin
				burst = $urandom_range(1, 13);
				hold_sink = 1;
				repeat (burst) @(posedge clk);
				hold_sink = 0;
			end
		end
	end

	// Offer one item; valid stays up so the next item can follow directly
	task automatic send_step(op_t op, logic signed [17:0] ang, logic signed [31:0] mu,
			logic signed [31:0] mv, logic signed [31:0] mn);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 13);
			in_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.op <= op;
		in_ch.angle_deg <= ang;
		in_ch.move_u <= mu;
		in_ch.move_v <= mv;
		in_ch.move_n <= mn;
		do @(posedge clk); while (!in_ch.ready);
		op_count[op]++;
		n_sent++;
	endtask

	function automatic logic signed [17:0] pick_angle();
		case ($urandom_range(0, 3))
			0: return 18'($urandom_range(0, 2 * 92160) - 92160);
			1: return 18'($urandom_range(0, 4096) - 2048);
			2: return 18'(23040 * $urandom_range(0, 8) - 92160);
			default: return 18'($urandom);
		endcase
	endfunction

	function automatic logic signed [31:0] pick_move();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 32'h60000) - 32'h30000;
			2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return 0;
		endcase
	endfunction

	// Drop valid and wait until every expected report has come back
	task automatic wait_drain();
		in_ch.valid <= 0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		op_t op;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: angle extremes, folds, every op, slide saturation, unused fields
		send_step(OP_ROLL, 0, 0, 0, 0);
		send_step(OP_ROLL, 18'sd92160, 32'sh7fffffff, 0, 0);
		send_step(OP_ROLL, -18'sd92160, 0, 0, 0);
		send_step(OP_PITCH, 18'sd23040, 0, 0, 0);
		send_step(OP_PITCH, 18'sd23041, 0, 0, 0);
		send_step(OP_PITCH, -18'sd23041, 0, 0, 0);
		send_step(OP_YAW, 18'sd46080, 0, 0, 0);
		send_step(OP_YAW, -18'sd46080, 0, 0, 0);
		send_step(OP_YAW, 18'sh1ffff, 0, 0, 0);
		send_step(OP_YAW, 18'sh20000, 0, 0, 0);
		send_step(OP_ROLL, 18'sd11520, -1, -1, -1);
		send_step(OP_SLIDE, 18'sh1ffff, 32'sh10000, 32'sh10000, 32'sh10000);
		send_step(OP_SLIDE, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send_step(OP_SLIDE, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send_step(OP_SLIDE, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_step(OP_SLIDE, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_step(OP_SLIDE, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_step(OP_SLIDE, 0, -32'sh10000, 32'sh8000, 32'sh1);

		// Sender pauses until every report is back
		wait_drain();

		// Receiver holds off while the sender keeps offering
		fork
			begin
				long_hold = 1;
				repeat (300) @(posedge clk);
				long_hold = 0;
			end
			for (int i = 0; i < 4; i++)
				send_step(OP_SLIDE, 0, pick_move(), pick_move(), pick_move());
		join

		// Random mix; idling stops for the last stretch
		for (int i = 0; i < 1000; i++) begin
			if (i == 850) idle_on = 0;
			op = op_t'($urandom_range(0, 3));
			send_step(op, pick_angle(), pick_move(), pick_move(), pick_move());
		end

		wait_drain();
		repeat (60) @(posedge clk);
		$display("sent %0d steps: roll %0d pitch %0d yaw %0d slide %0d, %0d reports checked",
			n_sent, op_count[0], op_count[1], op_count[2], op_count[3], board.reports);
		$display("covered angle wrap/fold, saturating slides, stalls on both sides");
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("tb_camera_frame_rotate_slide_top: clean");
		else
			$display("tb_camera_frame_rotate_slide_top: errors");
		$finish;
	end
endmodule
